>>> src/wlsq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control structs of the windowed log sender.
// Used by wlsq_ctrl, wlsq_dp and the top level; depends on nothing.
package wlsq_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int ERROR_DEPTH = 8;
    localparam int FRAME_STORE = 16;

    localparam int ERR_PTR_W = $clog2(ERROR_DEPTH);
    localparam int ERR_CNT_W = $clog2(ERROR_DEPTH + 1);
    localparam int IDX_W     = $clog2(FRAME_STORE);
    localparam int STEP_W    = $clog2(MAX_WINDOW);

    // Request codes
    localparam logic [2:0] REQ_RX_DATA   = 3'd0;
    localparam logic [2:0] REQ_RX_INFO   = 3'd1;
    localparam logic [2:0] REQ_RX_ACK    = 3'd2;
    localparam logic [2:0] REQ_RX_OTHER  = 3'd3;
    localparam logic [2:0] REQ_SEND_WIN  = 3'd4;
    localparam logic [2:0] REQ_LOG_ERROR = 3'd5;

    // Frame kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_NOTHING = 2'd3;

    // Ack timer actions
    localparam logic [1:0] TMR_LEAVE = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    // Next-state requests
    localparam logic NXT_IDLE   = 1'b0;
    localparam logic NXT_WINDOW = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_LAST_BLOCK  = 1'b1;

    localparam logic [3:0] REM_END_BLOCK = 4'(MAX_WINDOW);
    localparam logic [3:0] REM_END_LOG   = 4'(MAX_WINDOW + 1);

    typedef struct packed {
        logic load;   // latch the accepted item
        logic step;   // produce one result and update state
    } ctrl_cmd_t;

    typedef struct packed {
        logic final_step;  // the current step gives the item's final result
    } dp_status_t;

    typedef struct packed {
        logic [1:0] frame_type;
        logic [7:0] frame_id;
        logic [3:0] remaining;
        logic [3:0] buffer_index;
        logic       next_state;
        logic [1:0] timer_action;
        logic       last;
    } result_t;

endpackage

>>> src/wlsq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the windowed log sender: item handshake, result register
// valid and the step sequencing. Depends on wlsq_pkg.
module wlsq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wlsq_pkg::ctrl_cmd_t   cmd,
    input  wlsq_pkg::dp_status_t  sts
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load = in_valid && (state_reg == S_IDLE);
        cmd.step = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd.step && sts.final_step)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EXEC)
        else $error("load did not enter execution");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && sts.final_step |=> state_reg == S_IDLE)
        else $error("final step did not return to idle");

    a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !cmd.step)
        else $error("step issued while idle");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid_reg)
        else $error("step did not present a result");

endmodule

>>> src/wlsq_dp.sv
`timescale 1ns / 1ps
// Datapath of the windowed log sender: item latch, link state, error ring,
// window frame stepping and the result register. Depends on wlsq_pkg.
module wlsq_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wlsq_pkg::ctrl_cmd_t   cmd,
    output wlsq_pkg::dp_status_t  sts,
    input  logic [2:0]            in_req_type,
    input  logic [7:0]            in_msg_id,
    input  logic                  in_ack_timeout_expired,
    input  logic [6:0]            in_error_code,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [7:0]            cfg_wdata,
    output wlsq_pkg::result_t     result
);

    // Configuration
    logic [4:0] frame_count_reg;
    logic [7:0] last_block_reg;

    // Latched item
    logic [2:0] req_reg;
    logic [7:0] id_reg;
    logic       expired_reg;
    logic [6:0] code_reg;

    // Link state
    logic [7:0] cursor_reg,       cursor_next;
    logic [3:0] window_reg,       window_next;
    logic [7:0] expected_ack_reg, expected_ack_next;
    logic [7:0] block_number_reg, block_number_next;
    logic [1:0] last_sent_reg,    last_sent_next;
    logic [wlsq_pkg::ERR_PTR_W-1:0] err_rd_ptr_reg, err_rd_ptr_next;
    logic [wlsq_pkg::ERR_CNT_W-1:0] err_count_reg,  err_count_next;
    logic [wlsq_pkg::STEP_W-1:0]    step_reg,       step_next;

    // Error ring
    logic [6:0] err_mem [wlsq_pkg::ERROR_DEPTH];
    logic [6:0] err_head_reg;
    logic       err_we;
    logic [wlsq_pkg::ERR_PTR_W-1:0] err_slot;

    wlsq_pkg::result_t result_reg, result_next;
    logic final_step;

    // Window stepping terms
    logic [4:0] count;
    logic [7:0] base;
    logic [8:0] pos;
    logic [8:0] count_ext;
    logic [3:0] step_ext;
    logic       has_frame;
    logic       next_has;
    logic [6:0] head;

    always_comb
    begin
        count     = (frame_count_reg > 5'(wlsq_pkg::FRAME_STORE)) ?
                    5'(wlsq_pkg::FRAME_STORE) : frame_count_reg;
        count_ext = {4'd0, count};
        base      = (cursor_reg == 8'd0) ? 8'd1 : cursor_reg;
        step_ext  = {1'b0, step_reg};
        pos       = {1'b0, base} + {6'd0, step_reg} - 9'd1;
        has_frame = (step_ext < window_reg) && (pos < count_ext);
        next_has  = ((step_ext + 4'd1) < window_reg) && ((pos + 9'd1) < count_ext);
        head      = (err_count_reg != '0) ? err_head_reg : 7'd0;
        err_slot  = err_rd_ptr_reg + err_count_reg[wlsq_pkg::ERR_PTR_W-1:0];
    end

    always_comb
    begin
        cursor_next       = cursor_reg;
        window_next       = window_reg;
        expected_ack_next = expected_ack_reg;
        block_number_next = block_number_reg;
        last_sent_next    = last_sent_reg;
        err_rd_ptr_next   = err_rd_ptr_reg;
        err_count_next    = err_count_reg;
        step_next         = step_reg;
        err_we            = 1'b0;
        final_step        = 1'b1;

        result_next              = '0;
        result_next.frame_type   = wlsq_pkg::KIND_NONE;
        result_next.next_state   = wlsq_pkg::NXT_IDLE;
        result_next.timer_action = wlsq_pkg::TMR_LEAVE;

        case (req_reg)
            wlsq_pkg::REQ_RX_DATA:
            begin
                if (id_reg <= last_block_reg)
                begin
                    if (id_reg > block_number_reg)
                    begin
                        block_number_next = id_reg;
                        cursor_next       = 8'd1;
                    end
                    result_next.next_state = wlsq_pkg::NXT_WINDOW;
                end
            end
            wlsq_pkg::REQ_RX_INFO:
            begin
                result_next.remaining = 4'd1;
                if (head != 7'd0)
                begin
                    result_next.frame_type = wlsq_pkg::KIND_ERROR;
                    result_next.frame_id   = {1'b0, head};
                    last_sent_next         = wlsq_pkg::KIND_ERROR;
                end
                else
                begin
                    result_next.frame_type = wlsq_pkg::KIND_NOTHING;
                    result_next.frame_id   = 8'd1;
                    last_sent_next         = wlsq_pkg::KIND_NOTHING;
                end
            end
            wlsq_pkg::REQ_RX_ACK:
            begin
                if (last_sent_reg == wlsq_pkg::KIND_ERROR)
                begin
                    // pop the reported error
                    if (err_count_reg != '0)
                    begin
                        err_rd_ptr_next = err_rd_ptr_reg + 1'b1;
                        err_count_next  = err_count_reg - 1'b1;
                    end
                end
                else if (last_sent_reg == wlsq_pkg::KIND_DATA)
                begin
                    cursor_next = id_reg;
                    if (id_reg == expected_ack_reg)
                    begin
                        if (window_reg < 4'(wlsq_pkg::MAX_WINDOW - 1))
                            window_next = window_reg + 4'd1;
                    end
                    else if (expired_reg)
                    begin
                        if (window_reg > 4'd1)
                            window_next = window_reg >> 1;
                    end
                    result_next.next_state = (id_reg >= {3'd0, count}) ?
                                             wlsq_pkg::NXT_IDLE : wlsq_pkg::NXT_WINDOW;
                    result_next.timer_action = wlsq_pkg::TMR_STOP;
                end
            end
            wlsq_pkg::REQ_SEND_WIN:
            begin
                // one data frame per step, from the cursor on
                if (has_frame)
                begin
                    final_step                = !next_has;
                    result_next.frame_type    = wlsq_pkg::KIND_DATA;
                    result_next.frame_id      = base + {5'd0, step_reg};
                    result_next.buffer_index  = pos[wlsq_pkg::IDX_W-1:0];
                    if (pos == count_ext - 9'd1)
                        result_next.remaining = (block_number_reg >= last_block_reg) ?
                                                wlsq_pkg::REM_END_LOG :
                                                wlsq_pkg::REM_END_BLOCK;
                    else
                        result_next.remaining = window_reg - step_ext;
                    if (!next_has)
                        result_next.timer_action = wlsq_pkg::TMR_START;
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    result_next.timer_action = wlsq_pkg::TMR_START;
                end
                if (final_step)
                begin
                    expected_ack_next = base + {5'd0, step_reg} + {7'd0, has_frame};
                    last_sent_next    = wlsq_pkg::KIND_DATA;
                end
            end
            wlsq_pkg::REQ_LOG_ERROR:
            begin
                err_we = 1'b1;
                // full ring: drop the oldest entry
                if (err_count_reg >= wlsq_pkg::ERR_CNT_W'(wlsq_pkg::ERROR_DEPTH))
                    err_rd_ptr_next = err_rd_ptr_reg + 1'b1;
                else
                    err_count_next = err_count_reg + 1'b1;
            end
            default:
            begin
                result_next.frame_type = wlsq_pkg::KIND_NONE;
            end
        endcase

        result_next.last = final_step;
    end

    assign sts.final_step = final_step;
    assign result         = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= 5'(wlsq_pkg::FRAME_STORE);
            last_block_reg   <= 8'd4;
            cursor_reg       <= 8'd1;
            window_reg       <= 4'd1;
            expected_ack_reg <= 8'd1;
            block_number_reg <= 8'd0;
            last_sent_reg    <= wlsq_pkg::KIND_NOTHING;
            err_rd_ptr_reg   <= '0;
            err_count_reg    <= '0;
            step_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    wlsq_pkg::CFG_FRAME_COUNT: frame_count_reg <= cfg_wdata[4:0];
                    wlsq_pkg::CFG_LAST_BLOCK:  last_block_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load)
                step_reg <= '0;
            else if (cmd.step)
            begin
                cursor_reg       <= cursor_next;
                window_reg       <= window_next;
                expected_ack_reg <= expected_ack_next;
                block_number_reg <= block_number_next;
                last_sent_reg    <= last_sent_next;
                err_rd_ptr_reg   <= err_rd_ptr_next;
                err_count_reg    <= err_count_next;
                step_reg         <= step_next;
            end
        end
    end

    // Item latch and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= in_req_type;
            id_reg      <= in_msg_id;
            expired_reg <= in_ack_timeout_expired;
            code_reg    <= in_error_code;
        end
        if (cmd.step)
            result_reg <= result_next;
    end

    // Error ring storage, head read registered every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.step && err_we)
            err_mem[err_slot] <= code_reg;
        err_head_reg <= err_mem[err_rd_ptr_reg];
    end

endmodule

>>> src/windowed_log_sender_with_error_queue.sv
`timescale 1ns / 1ps
// Windowed log sender with error queue: slave side of a log transfer link.
// Each input item on s_axis is one link event (tuser = request type); each
// result item on m_axis is one frame decision, tlast marking the final result
// of an event. Configuration registers (frame_count, last_block) are to be written
// through cfg_we / cfg_addr / cfg_wdata only while the block is idle; the block itself does not enforce this.
// Timing: an item is accepted in the idle state into the item latch; its first result
// is then registered into the result register. A send-window event emits up to seven
// data frames, one per cycle while the receiver takes them; every other event gives
// one result. The sequencer produces one result per cycle into the single result
// register and accepts no new item until the final result of the current one is
// registered. A stalled m_axis holds the result register and the sequencer waits.
// Reset: cursor, window and expected ack go to 1, block to 0, last sent to the
// nothing frame, error queue empty; frame_count resets to 16, last_block to 4.
// The error ring is not cleared; the queue count guards unwritten entries.
// Depends on wlsq_pkg, wlsq_ctrl and wlsq_dp.
module windowed_log_sender_with_error_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // msg_id[7:0], ack_timeout_expired[8], error_code[15:9]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // frame_id[7:0], remaining[11:8], buffer_index[15:12],
                                        // next_state[16], timer_action[18:17], zero[23:19]
    output logic [1:0]  m_axis_tuser,   // frame_type[1:0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    wlsq_pkg::ctrl_cmd_t  cmd;
    wlsq_pkg::dp_status_t sts;
    wlsq_pkg::result_t    result;

    wlsq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    wlsq_dp u_dp
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .sts                    (sts),
        .in_req_type            (s_axis_tuser),
        .in_msg_id              (s_axis_tdata[7:0]),
        .in_ack_timeout_expired (s_axis_tdata[8]),
        .in_error_code          (s_axis_tdata[15:9]),
        .cfg_we                 (cfg_we),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .result                 (result)
    );

    assign m_axis_tdata = {5'd0, result.timer_action, result.next_state,
                           result.buffer_index, result.remaining, result.frame_id};
    assign m_axis_tuser = result.frame_type;
    assign m_axis_tlast = result.last;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for windowed_log_sender_with_error_queue: a directed
// table, then random event sequences per config setting, each result checked
// against an in-bench predictor. Depends on wlsq_pkg and the RTL under src.
module tb_top;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASE_ITEMS   = 63;
    localparam int NUM_PHASES    = 7;

    // Request codes the block treats as unknown
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]        req;
        logic [7:0]        id;
        logic              expired;
        logic [6:0]        code;
        logic              typed;
        wlsq_pkg::result_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // msg_id[7:0], ack_timeout_expired[8], error_code[15:9]
    logic [2:0]  s_axis_tuser = '0;   // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // frame_id[7:0], remaining[11:8], buffer_index[15:12],
                                      // next_state[16], timer_action[18:17], zero[23:19]
    logic [1:0]  m_axis_tuser;        // frame_type[1:0]
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    // Predictor state
    logic [4:0]                     cfg_frames;
    logic [7:0]                     cfg_last_block;
    logic [7:0]                     sent_cursor;
    logic [3:0]                     sent_window;
    logic [7:0]                     ack_due;
    logic [7:0]                     cur_block;
    logic [1:0]                     last_kind;
    logic [6:0]                     err_ring [wlsq_pkg::ERROR_DEPTH];
    logic [wlsq_pkg::ERR_PTR_W-1:0] err_head;
    logic [wlsq_pkg::ERR_CNT_W-1:0] err_fill;

    wlsq_pkg::result_t frames_due [$];
    stim_row_t         stim_table [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int frames_seen = 0;
    int burst_left  = 0;
    bit hold_req    = 1'b0;

    windowed_log_sender_with_error_queue dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 100)
            $display("mismatch at result %0d: %s", frames_seen, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic wlsq_pkg::result_t mk_frame(input logic [1:0] ft, input logic [7:0] fid,
                                                   input logic [3:0] rem, input logic nxt,
                                                   input logic [1:0] tmr);
        wlsq_pkg::result_t r;
        r = '0;
        r.frame_type   = ft;
        r.frame_id     = fid;
        r.remaining    = rem;
        r.next_state   = nxt;
        r.timer_action = tmr;
        r.last         = 1'b1;
        return r;
    endfunction

    task automatic reset_predictor();
        cfg_frames     = 5'd16;
        cfg_last_block = 8'd4;
        sent_cursor    = 8'd1;
        sent_window    = 4'd1;
        ack_due        = 8'd1;
        cur_block      = 8'd0;
        last_kind      = wlsq_pkg::KIND_NOTHING;
        for (int k = 0; k < wlsq_pkg::ERROR_DEPTH; k++)
            err_ring[k] = '0;
        err_head = '0;
        err_fill = '0;
    endtask

    // Work out the frames one link event produces and queue them.
    task automatic predict_event(input logic [2:0] req, input logic [7:0] id,
                                 input logic expired, input logic [6:0] code);
        wlsq_pkg::result_t r;
        logic [6:0]        head;
        int                count;
        int                base;
        int                i;
        int                pos;
        int                slot;
        count = (cfg_frames > wlsq_pkg::FRAME_STORE) ? wlsq_pkg::FRAME_STORE : int'(cfg_frames);
        r = '0;
        r.last = 1'b1;
        case (req)
            wlsq_pkg::REQ_RX_DATA:
            begin
                if (id <= cfg_last_block)
                begin
                    if (id > cur_block)
                    begin
                        cur_block   = id;
                        sent_cursor = 8'd1;
                    end
                    r.next_state = wlsq_pkg::NXT_WINDOW;
                end
                frames_due.push_back(r);
            end
            wlsq_pkg::REQ_RX_INFO:
            begin
                head = (err_fill > 0) ? err_ring[err_head] : '0;
                if (head != 0)
                begin
                    r = mk_frame(wlsq_pkg::KIND_ERROR, 8'(head), 4'd1, wlsq_pkg::NXT_IDLE,
                                 wlsq_pkg::TMR_LEAVE);
                    last_kind = wlsq_pkg::KIND_ERROR;
                end
                else
                begin
                    r = mk_frame(wlsq_pkg::KIND_NOTHING, 8'd1, 4'd1, wlsq_pkg::NXT_IDLE,
                                 wlsq_pkg::TMR_LEAVE);
                    last_kind = wlsq_pkg::KIND_NOTHING;
                end
                frames_due.push_back(r);
            end
            wlsq_pkg::REQ_RX_ACK:
            begin
                if (last_kind == wlsq_pkg::KIND_ERROR)
                begin
                    if (err_fill > 0)
                    begin
                        err_head = wlsq_pkg::ERR_PTR_W'((int'(err_head) + 1) %
                                                        wlsq_pkg::ERROR_DEPTH);
                        err_fill = err_fill - 1'b1;
                    end
                end
                else if (last_kind == wlsq_pkg::KIND_DATA)
                begin
                    sent_cursor = id;
                    if (id == ack_due)
                    begin
                        if (sent_window < wlsq_pkg::MAX_WINDOW - 1)
                            sent_window = sent_window + 1'b1;
                    end
                    else if (expired && sent_window > 1)
                        sent_window = sent_window >> 1;
                    r.next_state   = (int'(id) >= count) ? wlsq_pkg::NXT_IDLE
                                                         : wlsq_pkg::NXT_WINDOW;
                    r.timer_action = wlsq_pkg::TMR_STOP;
                end
                frames_due.push_back(r);
            end
            wlsq_pkg::REQ_SEND_WIN:
            begin
                // a cursor of zero sends as if it were one
                base = (sent_cursor == 0) ? 1 : int'(sent_cursor);
                i = 0;
                while (i < sent_window && i + base - 1 < count)
                begin
                    pos = i + base - 1;
                    r = '0;
                    r.frame_type   = wlsq_pkg::KIND_DATA;
                    r.frame_id     = 8'(i + base);
                    r.buffer_index = 4'(pos);
                    if (pos == count - 1)
                        r.remaining = (cur_block >= cfg_last_block) ? wlsq_pkg::REM_END_LOG
                                                                    : wlsq_pkg::REM_END_BLOCK;
                    else
                        r.remaining = 4'(int'(sent_window) - i);
                    if (!(i + 1 < sent_window && i + base < count))
                    begin
                        r.timer_action = wlsq_pkg::TMR_START;
                        r.last         = 1'b1;
                    end
                    frames_due.push_back(r);
                    i++;
                end
                ack_due   = 8'(i + base);
                last_kind = wlsq_pkg::KIND_DATA;
                if (i == 0)
                    frames_due.push_back(mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0,
                                                  wlsq_pkg::NXT_IDLE, wlsq_pkg::TMR_START));
            end
            wlsq_pkg::REQ_LOG_ERROR:
            begin
                slot = (int'(err_head) + int'(err_fill)) % wlsq_pkg::ERROR_DEPTH;
                err_ring[slot] = code;
                // full ring: drop the oldest entry
                if (err_fill >= wlsq_pkg::ERROR_DEPTH)
                    err_head = wlsq_pkg::ERR_PTR_W'((int'(err_head) + 1) %
                                                    wlsq_pkg::ERROR_DEPTH);
                else
                    err_fill = err_fill + 1'b1;
                frames_due.push_back(r);
            end
            default:
                frames_due.push_back(r);
        endcase
    endtask

    task automatic offer_item(input logic [2:0] req, input logic [7:0] id,
                              input logic expired, input logic [6:0] code);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {code, expired, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic run_event(input logic [2:0] req, input logic [7:0] id,
                             input logic expired, input logic [6:0] code);
        predict_event(req, id, expired, code);
        offer_item(req, id, expired, code);
    endtask

    // Hold off input and wait until every queued frame has arrived.
    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic addr, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        if (addr == wlsq_pkg::CFG_FRAME_COUNT)
            cfg_frames = value[4:0];
        else
            cfg_last_block = value;
    endtask

    function automatic logic [7:0] pick_ack_id();
        int count;
        int sel;
        count = (cfg_frames > wlsq_pkg::FRAME_STORE) ? wlsq_pkg::FRAME_STORE : int'(cfg_frames);
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return ack_due;
        else if (sel < 85)
            return 8'($urandom_range(0, count));
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: segments of steady, random, alternating or sparse readiness.
    initial
    begin : rx_side
        int mode;
        int seg;
        int tick;
        tick = 0;
        forever
        begin
            if (hold_req)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    m_axis_tready <= 1'b0;
                end
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(4, 64);
            repeat (seg)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= 1'(tick % 2);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : frame_check
        wlsq_pkg::result_t got;
        wlsq_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.frame_type   = m_axis_tuser;
            got.frame_id     = m_axis_tdata[7:0];
            got.remaining    = m_axis_tdata[11:8];
            got.buffer_index = m_axis_tdata[15:12];
            got.next_state   = m_axis_tdata[16];
            got.timer_action = m_axis_tdata[18:17];
            got.last         = m_axis_tlast;
            if (frames_due.size() == 0)
                report_mismatch("frame with no expectation waiting");
            else
            begin
                want = frames_due.pop_front();
                check_field("frame_type", got.frame_type, want.frame_type);
                check_field("frame_id", got.frame_id, want.frame_id);
                check_field("remaining", got.remaining, want.remaining);
                check_field("buffer_index", got.buffer_index, want.buffer_index);
                check_field("next_state", got.next_state, want.next_state);
                check_field("timer_action", got.timer_action, want.timer_action);
                check_field("last", got.last, want.last);
                check_field("tdata pad", m_axis_tdata[23:19], 0);
            end
            frames_seen++;
        end
    end

    initial
    begin : stimulus
        int        fc_set [NUM_PHASES];
        int        lb_set [NUM_PHASES];
        int        issued;
        int        pick;
        bit        hold_sent;
        stim_row_t row;

        fc_set = '{16, 3, 16, 31, 0, 1, 0};
        lb_set = '{4, 0, 255, 2, 9, 255, 0};
        fc_set[6] = $urandom_range(0, 16);
        lb_set[6] = $urandom_range(0, 255);
        hold_sent = 1'b0;

        // Directed rows, starting from reset values
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_INFO, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NOTHING, 8'd1, 4'd1, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd5, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_OTHER, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{REQ_SPARE_6, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{REQ_SPARE_7, 8'd255, 1'b1, 7'd127, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_DATA, 8'd255, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_DATA, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_WINDOW,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_SEND_WIN, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_DATA, 8'd1, 4'd1, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_START)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd2, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_WINDOW,
                     wlsq_pkg::TMR_STOP)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_SEND_WIN, 8'd0, 1'b0, 7'd0, 1'b0, '0});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd4, 1'b0, 7'd0, 1'b0, '0});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_SEND_WIN, 8'd0, 1'b0, 7'd0, 1'b0, '0});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd3, 1'b1, 7'd0, 1'b0, '0});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_LOG_ERROR, 8'd0, 1'b0, 7'd127, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_LOG_ERROR, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_INFO, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_ERROR, 8'd127, 4'd1, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        // a queued zero code reads as no error and stays at the head
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_INFO, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NOTHING, 8'd1, 4'd1, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd7, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_DATA, 8'd4, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_WINDOW,
                     wlsq_pkg::TMR_LEAVE)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_SEND_WIN, 8'd0, 1'b0, 7'd0, 1'b0, '0});
        // ack of zero, then a window that starts at one
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd0, 1'b1, 7'd0, 1'b0, '0});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_SEND_WIN, 8'd0, 1'b0, 7'd0, 1'b0, '0});
        // cursor past the frame count leaves an empty window
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_RX_ACK, 8'd200, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_STOP)});
        stim_table.push_back(stim_row_t'{wlsq_pkg::REQ_SEND_WIN, 8'd0, 1'b0, 7'd0, 1'b1,
            mk_frame(wlsq_pkg::KIND_NONE, 8'd0, 4'd0, wlsq_pkg::NXT_IDLE,
                     wlsq_pkg::TMR_START)});

        reset_predictor();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[n])
        begin
            row = stim_table[n];
            predict_event(row.req, row.id, row.expired, row.code);
            if (row.typed)
            begin
                void'(frames_due.pop_back());
                frames_due.push_back(row.res);
            end
            offer_item(row.req, row.id, row.expired, row.code);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_frames();
                write_cfg(wlsq_pkg::CFG_FRAME_COUNT, 8'(fc_set[phase]));
                write_cfg(wlsq_pkg::CFG_LAST_BLOCK, 8'(lb_set[phase]));
                cfg_we <= 1'b0;
            end
            issued = 0;
            while (issued < PHASE_ITEMS)
            begin
                if (phase == 1 && issued >= 10 && !hold_sent)
                begin
                    hold_req  = 1'b1;
                    hold_sent = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    run_event(wlsq_pkg::REQ_SEND_WIN, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                    run_event(wlsq_pkg::REQ_RX_ACK, pick_ack_id(), 1'($urandom_range(0, 1)),
                              7'($urandom_range(0, 127)));
                    issued += 2;
                end
                else if (pick < 55)
                begin
                    run_event(wlsq_pkg::REQ_RX_DATA,
                              ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, cfg_last_block))
                                                          : 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                    issued++;
                end
                else if (pick < 70)
                begin
                    run_event(wlsq_pkg::REQ_LOG_ERROR, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(0, 127)));
                    issued++;
                end
                else if (pick < 85)
                begin
                    run_event(wlsq_pkg::REQ_RX_INFO, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                    run_event(wlsq_pkg::REQ_RX_ACK, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                    issued += 2;
                end
                else if (pick < 92)
                begin
                    run_event(wlsq_pkg::REQ_RX_ACK, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                    issued++;
                end
                else
                begin
                    run_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                    issued++;
                end
            end
        end

        drain_frames();
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
